/* hw/rtl/bsp_pkg.sv */
package bsp_pkg;

   // Store geometry. The 7-bit fill level and rotate amount fields limit the depth to 127 at most.
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Operation codes.
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_MIRROR = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_NOROT = 2'd3;

   // One request.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] push_byte;
      logic [6:0] rotate_amount;
   } bsp_req_type;

   // One response.
   typedef struct packed {
      logic [7:0] pop_byte;
      logic       is_mirror;
      logic [1:0] status;
      logic [6:0] fill_level;
   } bsp_rsp_type;

   // Access to the byte store: one write port and two read ports.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } bsp_mem_ctl_type;

endpackage

/* hw/rtl/bsp_store.sv */
module bsp_store (
   input  logic                     clock,
   input  bsp_pkg::bsp_mem_ctl_type mem_ctl,
   output logic [7:0]               rd_data_a,
   output logic [7:0]               rd_data_b
);

   logic [7:0] mem_ff [bsp_pkg::STACK_DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   // Synchronous store with registered read data on both ports.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_ctl.wr_addr] <= mem_ctl.wr_data;
      end
      rd_a_ff <= mem_ff[mem_ctl.rd_addr_a];
      rd_b_ff <= mem_ff[mem_ctl.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/byte_stack_palindrome_rotate.sv */
// Bounded LIFO stack of bytes with a palindrome check and a rotate.
// A request is taken on a rising edge with start high and busy low; it carries
// an opcode (push, pop, palindrome check, rotate), a byte to push and a rotate
// amount. Every request gives exactly one response, shown on rsp_data for a
// single cycle with rsp_valid high; the receiver has no way to hold it off.
// Pushes, refused pops, refused or trivial rotates and rotates of a full stack are
// answered straight from the idle state; pops, palindrome checks and rotates that
// copy entries pass through a working state first.
// Requests answered from idle leave busy low, so requests of that kind may follow
// back to back. For the longer ones busy is high from acceptance until the
// response appears, and the next request may be taken in the cycle that shows the
// response. The longer requests wait on the single store: a pop waits for its
// read data, the palindrome check reads one pair of entries a cycle through both
// read ports, and the rotate copies one entry a cycle through the write port.
// The stack is held as a circular window over the store, so a rotate copies
// only the bottom entries above the top.
// Reset empties the stack at once; the store itself is never cleared.
module byte_stack_palindrome_rotate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bsp_pkg::bsp_req_type req_data,
   output logic                 rsp_valid,
   output bsp_pkg::bsp_rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_POP    = 2'd1;
   localparam logic [1:0] S_MIRROR = 2'd2;
   localparam logic [1:0] S_ROTATE = 2'd3;

   localparam int AW = bsp_pkg::ADDR_W;
   localparam int CW = bsp_pkg::CNT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(bsp_pkg::STACK_DEPTH);

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        bot_ff, bot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bsp_pkg::bsp_rsp_type rsp_ff, rsp_in;
   logic [AW-1:0]        lo_ff, lo_in;
   logic [AW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        pairs_ff, pairs_in;
   logic                 pend_ff, pend_in;
   logic                 mism_ff, mism_in;
   logic [CW-1:0]        step_ff, step_in;
   logic [CW-1:0]        amount_ff, amount_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;

   bsp_pkg::bsp_mem_ctl_type mem_ctl;
   logic [7:0]               rd_data_a;
   logic [7:0]               rd_data_b;
   logic [AW-1:0]            top_addr;
   logic                     issue;

   bsp_store u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Physical slot just above the top of the stack.
   assign top_addr = bot_ff + count_ff[AW-1:0];

   // Next state, store access and response.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      bot_in       = bot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pairs_in     = pairs_ff;
      pend_in      = pend_ff;
      mism_in      = mism_ff;
      step_in      = step_ff;
      amount_in    = amount_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      mem_ctl      = '0;
      issue        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in            = '0;
               rsp_in.status     = bsp_pkg::ST_OK;
               rsp_in.fill_level = count_ff;
               case (req_data.opcode)
                  bsp_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_in.status = bsp_pkg::ST_FULL;
                     end else begin
                        mem_ctl.wr_en     = 1'b1;
                        mem_ctl.wr_addr   = top_addr;
                        mem_ctl.wr_data   = req_data.push_byte;
                        count_in          = count_ff + 1'b1;
                        rsp_in.fill_level = count_ff + 1'b1;
                     end
                  end
                  bsp_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bsp_pkg::ST_EMPTY;
                     end else begin
                        mem_ctl.rd_addr_a = top_addr - 1'b1;
                        count_in          = count_ff - 1'b1;
                        state_in          = S_POP;
                     end
                  end
                  bsp_pkg::OP_MIRROR: begin
                     lo_in    = '0;
                     hi_in    = AW'(count_ff - 1'b1);
                     pairs_in = AW'(count_ff >> 1);
                     pend_in  = 1'b0;
                     mism_in  = 1'b0;
                     state_in = S_MIRROR;
                  end
                  default: begin
                     // Rotate: refused, trivial, a pure window shift when full,
                     // or a copy of the bottom entries above the top.
                     if (count_ff == '0 || req_data.rotate_amount > count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bsp_pkg::ST_NOROT;
                     end else if (req_data.rotate_amount == '0 ||
                                  req_data.rotate_amount == count_ff) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == FULL_COUNT) begin
                        bot_in       = bot_ff + req_data.rotate_amount[AW-1:0];
                        rsp_valid_in = 1'b1;
                     end else begin
                        step_in    = '0;
                        amount_in  = req_data.rotate_amount;
                        wr_pend_in = 1'b0;
                        state_in   = S_ROTATE;
                     end
                  end
               endcase
            end
         end

         S_POP: begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.pop_byte   = rd_data_a;
            rsp_in.status     = bsp_pkg::ST_OK;
            rsp_in.fill_level = count_ff;
            state_in          = S_IDLE;
         end

         S_MIRROR: begin
            // Read one pair from the two ends a cycle, and compare it in the cycle after.
            issue = (pairs_ff != '0);
            if (issue) begin
               mem_ctl.rd_addr_a = bot_ff + lo_ff;
               mem_ctl.rd_addr_b = bot_ff + hi_ff;
               lo_in             = lo_ff + 1'b1;
               hi_in             = hi_ff - 1'b1;
               pairs_in          = pairs_ff - 1'b1;
            end
            pend_in = issue;
            if (pend_ff && (rd_data_a != rd_data_b)) begin
               mism_in = 1'b1;
            end
            if (!issue && !pend_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = '0;
               rsp_in.is_mirror  = !mism_ff;
               rsp_in.status     = bsp_pkg::ST_OK;
               rsp_in.fill_level = count_ff;
               state_in          = S_IDLE;
            end
         end

         S_ROTATE: begin
            // Copy bottom entry k to the slot k above the top, then move the
            // bottom of the window up by the amount.
            issue = (step_ff != amount_ff);
            if (issue) begin
               mem_ctl.rd_addr_a = bot_ff + step_ff[AW-1:0];
               wr_addr_in        = top_addr + step_ff[AW-1:0];
               step_in           = step_ff + 1'b1;
            end
            wr_pend_in = issue;
            if (wr_pend_ff) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = wr_addr_ff;
               mem_ctl.wr_data = rd_data_a;
            end
            if (!issue && !wr_pend_ff) begin
               bot_in            = bot_ff + amount_ff[AW-1:0];
               rsp_valid_in      = 1'b1;
               rsp_in            = '0;
               rsp_in.status     = bsp_pkg::ST_OK;
               rsp_in.fill_level = count_ff;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bot_ff       <= bot_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   // Working and response registers.
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      pairs_ff   <= pairs_in;
      mism_ff    <= mism_in;
      step_ff    <= step_in;
      amount_ff  <= amount_in;
      wr_addr_ff <= wr_addr_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/bsp_checker.sv */
module bsp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input bsp_pkg::bsp_rsp_type rsp_data
);

   // No response straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response shown right after reset");

   // An accepted request either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   // A refused pop reports an empty stack and no byte.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == bsp_pkg::ST_EMPTY) |->
      (rsp_data.pop_byte == 8'd0 && rsp_data.fill_level == 7'd0))
      else $error("empty pop with data or non-zero fill level");

   // A refused push reports a full stack.
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == bsp_pkg::ST_FULL) |->
      (rsp_data.fill_level == 7'(bsp_pkg::STACK_DEPTH)))
      else $error("full push with fill level below depth");

   // The fill level never passes the depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fill_level <= 7'(bsp_pkg::STACK_DEPTH)))
      else $error("fill level beyond depth");

endmodule

bind byte_stack_palindrome_rotate bsp_checker u_bsp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* bench/byte_stack_palindrome_rotate_checker.sv */
module byte_stack_palindrome_rotate_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  bsp_pkg::bsp_req_type req_data,
   input  logic                 rsp_valid,
   input  bsp_pkg::bsp_rsp_type rsp_data,
   output int                   error_count,
   output int                   awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bsp_pkg::*;

   // Shadow copy of the stack: entry 0 is the bottom.
   logic [7:0]  shadow_bytes [STACK_DEPTH];
   int          shadow_count;

   // Responses predicted for accepted requests, oldest first.
   bsp_rsp_type awaited_rsp_q [$];
   bsp_rsp_type want;

   // True when the held bytes read the same from either end.
   function automatic logic shadow_is_mirror();
      int lo;
      int hi;
      lo = 0;
      hi = shadow_count - 1;
      while (lo < hi) begin
         if (shadow_bytes[lo] != shadow_bytes[hi]) return 1'b0;
         lo++;
         hi--;
      end
      return 1'b1;
   endfunction

   // Applies one request to the shadow stack and returns the response it should give.
   function automatic bsp_rsp_type apply_stack_op(input bsp_req_type r);
      bsp_rsp_type res;
      logic [7:0]  rotated [STACK_DEPTH];
      int          amount;
      int          rest;
      int          k;
      res = '0;
      res.status = ST_OK;
      amount = int'(r.rotate_amount);
      case (r.opcode)
         OP_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_bytes[shadow_count] = r.push_byte;
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_count--;
               res.pop_byte = shadow_bytes[shadow_count];
            end
         end
         OP_MIRROR: begin
            res.is_mirror = shadow_is_mirror();
         end
         OP_ROTATE: begin
            if (shadow_count == 0 || amount > shadow_count) begin
               res.status = ST_NOROT;
            end else if (amount != 0 && amount != shadow_count) begin
               // The upper entries drop to the bottom, then the bottom ones follow in order.
               rest = shadow_count - amount;
               for (k = 0; k < rest; k++) rotated[k] = shadow_bytes[amount + k];
               for (k = 0; k < amount; k++) rotated[rest + k] = shadow_bytes[k];
               for (k = 0; k < shadow_count; k++) shadow_bytes[k] = rotated[k];
            end
         end
      endcase
      res.fill_level = 7'(shadow_count);
      return res;
   endfunction

   // Compare the response of this edge first, then predict for a request taken at it.
   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         awaited_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp_q.size() == 0) begin
               $error("response with no request outstanding: %p", rsp_data);
               error_count++;
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_data.pop_byte !== want.pop_byte) begin
                  $error("pop_byte: expected %0d, got %0d", want.pop_byte, rsp_data.pop_byte);
                  error_count++;
               end
               if (rsp_data.is_mirror !== want.is_mirror) begin
                  $error("is_mirror: expected %0d, got %0d", want.is_mirror, rsp_data.is_mirror);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.fill_level !== want.fill_level) begin
                  $error("fill_level: expected %0d, got %0d", want.fill_level,
                         rsp_data.fill_level);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            awaited_rsp_q.push_back(apply_stack_op(req_data));
         end
      end
      awaited_count = awaited_rsp_q.size();
   end

endmodule

/* bench/byte_stack_palindrome_rotate_tb.sv */
module byte_stack_palindrome_rotate_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsp_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int ITEM_TARGET   = 1300;
   localparam int MAX_CYCLES    = 600000;
   localparam int SETTLE_CYCLES = STACK_DEPTH + 16;

   // Kinds of random phase.
   localparam int MODE_FILL   = 0;
   localparam int MODE_DRAIN  = 1;
   localparam int MODE_MIXED  = 2;
   localparam int MODE_MIRROR = 3;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   bsp_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   bsp_rsp_type rsp_data;
   int          error_count;
   int          awaited_count;
   int          cycle_count = 0;

   // Fill level the stimulus steers by, requests taken so far, and the idling switch.
   int          level = 0;
   int          issued = 0;
   bit          no_gaps = 1'b0;
   int          mode;
   int          run_len;

   always #HALF_PERIOD clock = ~clock;

   byte_stack_palindrome_rotate u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   byte_stack_palindrome_rotate_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("byte_stack_palindrome_rotate_tb: done, errors");
         $finish;
      end
   end

   // Presents one request after an optional idle gap and holds it until it is taken.
   task automatic issue_op(input logic [1:0] op, input logic [7:0] data,
                           input logic [6:0] amount);
      int          gap;
      bsp_req_type r;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      r.opcode        = op;
      r.push_byte     = data;
      r.rotate_amount = amount;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      issued++;
      case (op)
         OP_PUSH: if (level < STACK_DEPTH) level++;
         OP_POP:  if (level > 0) level--;
         default: ;
      endcase
   endtask

   // Rotate amounts cluster on the legal range and its edges, with the odd wild value.
   function automatic logic [6:0] pick_amount();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 7'($urandom_range(0, level));
      if (roll == 6) return 7'(level);
      if (roll == 7) return 7'(level + 1);
      if (roll == 8) return 7'($urandom_range(level, STACK_DEPTH));
      return 7'($urandom_range(0, 127));
   endfunction

   // Operation mix for each kind of phase.
   function automatic logic [1:0] pick_op(input int phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         MODE_FILL:
            return roll < 80 ? OP_PUSH : roll < 87 ? OP_POP : roll < 93 ? OP_MIRROR : OP_ROTATE;
         MODE_DRAIN:
            return roll < 75 ? OP_POP : roll < 83 ? OP_PUSH : roll < 91 ? OP_MIRROR : OP_ROTATE;
         default:
            return 2'($urandom_range(0, 3));
      endcase
   endfunction

   // Empties the stack, builds a palindrome, checks it, then issues rotates and checks in random order.
   task automatic build_mirror_run();
      logic [7:0] half [$];
      int         half_len;
      int         alphabet;
      bit         odd;
      int         k;
      half_len = $urandom_range(0, STACK_DEPTH / 2);
      alphabet = $urandom_range(0, 1) ? 255 : 3;
      odd = $urandom_range(0, 1) && (2 * half_len < STACK_DEPTH);
      while (level > 0) issue_op(OP_POP, 8'($urandom), 7'($urandom));
      for (k = 0; k < half_len; k++) begin
         half.push_back(8'($urandom_range(0, alphabet)));
         issue_op(OP_PUSH, half[k], 7'($urandom));
      end
      if (odd) issue_op(OP_PUSH, 8'($urandom_range(0, alphabet)), 7'($urandom));
      for (k = half_len - 1; k >= 0; k--) issue_op(OP_PUSH, half[k], 7'($urandom));
      // Now and then a stray byte spoils the symmetry.
      if ($urandom_range(0, 3) == 0) issue_op(OP_PUSH, 8'($urandom), 7'($urandom));
      issue_op(OP_MIRROR, 8'($urandom), 7'($urandom));
      repeat ($urandom_range(1, 4)) begin
         issue_op($urandom_range(0, 1) ? OP_ROTATE : OP_MIRROR, 8'($urandom), pick_amount());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-stack cases, byte extremes, rotate by zero, by the count and beyond.
      issue_op(OP_MIRROR, 8'($urandom), 7'($urandom));
      issue_op(OP_POP,    8'($urandom), 7'($urandom));
      issue_op(OP_ROTATE, 8'($urandom), 7'd0);
      issue_op(OP_ROTATE, 8'($urandom), 7'd127);
      issue_op(OP_PUSH,   8'h00, 7'($urandom));
      issue_op(OP_PUSH,   8'hFF, 7'($urandom));
      issue_op(OP_MIRROR, 8'($urandom), 7'($urandom));
      issue_op(OP_PUSH,   8'h00, 7'($urandom));
      issue_op(OP_MIRROR, 8'($urandom), 7'($urandom));
      issue_op(OP_ROTATE, 8'($urandom), 7'd0);
      issue_op(OP_ROTATE, 8'($urandom), 7'd3);
      issue_op(OP_ROTATE, 8'($urandom), 7'd4);
      issue_op(OP_ROTATE, 8'($urandom), 7'd1);
      issue_op(OP_MIRROR, 8'($urandom), 7'($urandom));
      issue_op(OP_ROTATE, 8'($urandom), 7'd2);
      issue_op(OP_MIRROR, 8'($urandom), 7'($urandom));
      issue_op(OP_PUSH,   8'hA5, 7'($urandom));
      issue_op(OP_ROTATE, 8'($urandom), 7'd64);
      repeat (4) issue_op(OP_POP, 8'($urandom), 7'($urandom));
      issue_op(OP_POP,    8'($urandom), 7'($urandom));

      // Random phases; the first one fills the stack so that the full case is reached early.
      while (issued < ITEM_TARGET) begin
         mode = (issued < 150) ? MODE_FILL : $urandom_range(0, 3);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (mode == MODE_MIRROR) begin
            build_mirror_run();
         end else begin
            run_len = $urandom_range(30, 100);
            repeat (run_len) begin
               issue_op(pick_op(mode), 8'($urandom), pick_amount());
            end
         end
      end
      start <= 1'b0;

      // Drain the outstanding responses, then give the block time to show anything stray.
      do @(negedge clock); while (awaited_count != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("byte_stack_palindrome_rotate_tb: done, clean");
      end else begin
         $display("byte_stack_palindrome_rotate_tb: done, errors");
      end
      $finish;
   end

endmodule
